### sv/bda_pkg.sv
package bda_pkg;

	// Key layout: buttons first, then the four joystick directions
	localparam int BUTTONS   = 5;
	localparam int ALL_KEYS  = BUTTONS + 4;
	localparam int KEY_RIGHT = BUTTONS;
	localparam int KEY_LEFT  = BUTTONS + 1;
	localparam int KEY_UP    = BUTTONS + 2;
	localparam int KEY_DOWN  = BUTTONS + 3;

	localparam int INTEG_MAX = 255;
	localparam int INTEG_W   = $clog2(INTEG_MAX + 1);

	localparam int STEP_W   = 8;
	localparam int LEVEL_W  = 12;
	localparam int REPEAT_W = 10;
	localparam int COUNT_W  = REPEAT_W + 1;
	localparam int SUM_W    = ((INTEG_W > STEP_W) ? INTEG_W : STEP_W) + 1;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = LEVEL_W;

	localparam int IN_FIELDS_W  = BUTTONS + 2 * LEVEL_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 2 * ALL_KEYS;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_STEP_UP        = 3'd0,
		CFG_STEP_DOWN      = 3'd1,
		CFG_UPPER_PRESS    = 3'd2,
		CFG_UPPER_RELEASE  = 3'd3,
		CFG_LOWER_PRESS    = 3'd4,
		CFG_LOWER_RELEASE  = 3'd5,
		CFG_REPEAT_DELAY   = 3'd6,
		CFG_REPEAT_PERIOD  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [STEP_W-1:0]   step_up;
		logic [STEP_W-1:0]   step_down;
		logic [LEVEL_W-1:0]  upper_press_level;
		logic [LEVEL_W-1:0]  upper_release_level;
		logic [LEVEL_W-1:0]  lower_press_level;
		logic [LEVEL_W-1:0]  lower_release_level;
		logic [REPEAT_W-1:0] repeat_delay;
		logic [REPEAT_W-1:0] repeat_period;
	} cfg_t;

endpackage

### sv/bda_cfg_regs.sv
module bda_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bda_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [bda_pkg::CFG_DATA_W-1:0]    cfg_data,
	output bda_pkg::cfg_t                     cfg
);

	bda_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_up             <= bda_pkg::STEP_W'(1);
			cfg_q.step_down           <= bda_pkg::STEP_W'(1);
			cfg_q.upper_press_level   <= bda_pkg::LEVEL_W'(3000);
			cfg_q.upper_release_level <= bda_pkg::LEVEL_W'(2800);
			cfg_q.lower_press_level   <= bda_pkg::LEVEL_W'(1000);
			cfg_q.lower_release_level <= bda_pkg::LEVEL_W'(1200);
			cfg_q.repeat_delay        <= bda_pkg::REPEAT_W'(30);
			cfg_q.repeat_period       <= bda_pkg::REPEAT_W'(3);
		end else if (cfg_valid) begin
			case (bda_pkg::cfg_reg_t'(cfg_index))
				bda_pkg::CFG_STEP_UP: begin
					cfg_q.step_up <= cfg_data[bda_pkg::STEP_W-1:0];
				end
				bda_pkg::CFG_STEP_DOWN: begin
					cfg_q.step_down <= cfg_data[bda_pkg::STEP_W-1:0];
				end
				bda_pkg::CFG_UPPER_PRESS: begin
					cfg_q.upper_press_level <= cfg_data[bda_pkg::LEVEL_W-1:0];
				end
				bda_pkg::CFG_UPPER_RELEASE: begin
					cfg_q.upper_release_level <= cfg_data[bda_pkg::LEVEL_W-1:0];
				end
				bda_pkg::CFG_LOWER_PRESS: begin
					cfg_q.lower_press_level <= cfg_data[bda_pkg::LEVEL_W-1:0];
				end
				bda_pkg::CFG_LOWER_RELEASE: begin
					cfg_q.lower_release_level <= cfg_data[bda_pkg::LEVEL_W-1:0];
				end
				bda_pkg::CFG_REPEAT_DELAY: begin
					cfg_q.repeat_delay <= cfg_data[bda_pkg::REPEAT_W-1:0];
				end
				bda_pkg::CFG_REPEAT_PERIOD: begin
					cfg_q.repeat_period <= cfg_data[bda_pkg::REPEAT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### sv/bda_debounce.sv
module bda_debounce (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  bda_pkg::cfg_t                     cfg,
	input  logic [bda_pkg::BUTTONS-1:0]       raw,
	input  logic [bda_pkg::LEVEL_W-1:0]       jx,
	input  logic [bda_pkg::LEVEL_W-1:0]       jy,
	output logic [bda_pkg::ALL_KEYS-1:0]      held_old,
	output logic [bda_pkg::ALL_KEYS-1:0]      held_new
);

	logic [bda_pkg::INTEG_W-1:0]  integ_q [bda_pkg::BUTTONS];
	logic [bda_pkg::INTEG_W-1:0]  integ_d [bda_pkg::BUTTONS];
	logic [bda_pkg::ALL_KEYS-1:0] held_q;
	logic [bda_pkg::ALL_KEYS-1:0] word;

	assign held_old = held_q;
	assign held_new = word;

	always_comb begin
		logic [bda_pkg::SUM_W-1:0] sum;
		logic [bda_pkg::SUM_W-1:0] cur;
		logic [bda_pkg::SUM_W-1:0] dn;
		word = held_q;
		sum  = '0;
		cur  = '0;
		dn   = '0;
		for (int i = 0; i < bda_pkg::BUTTONS; i++) begin
			cur = bda_pkg::SUM_W'(integ_q[i]);
			sum = cur + bda_pkg::SUM_W'(cfg.step_up);
			dn  = bda_pkg::SUM_W'(cfg.step_down);
			if (raw[i]) begin
				if (sum >= bda_pkg::SUM_W'(bda_pkg::INTEG_MAX)) begin
					integ_d[i] = bda_pkg::INTEG_W'(bda_pkg::INTEG_MAX);
					word[i]    = 1'b1;
				end else begin
					integ_d[i] = sum[bda_pkg::INTEG_W-1:0];
				end
			end else begin
				if (cur <= dn) begin
					integ_d[i] = '0;
					word[i]    = 1'b0;
				end else begin
					integ_d[i] = cur[bda_pkg::INTEG_W-1:0] - dn[bda_pkg::INTEG_W-1:0];
				end
			end
		end

		// Hysteresis per axis; a release test comes last so clear wins
		if (jx > cfg.upper_press_level)   word[bda_pkg::KEY_RIGHT] = 1'b1;
		if (jx < cfg.upper_release_level) word[bda_pkg::KEY_RIGHT] = 1'b0;
		if (jx < cfg.lower_press_level)   word[bda_pkg::KEY_LEFT]  = 1'b1;
		if (jx > cfg.lower_release_level) word[bda_pkg::KEY_LEFT]  = 1'b0;
		if (jy > cfg.upper_press_level)   word[bda_pkg::KEY_UP]    = 1'b1;
		if (jy < cfg.upper_release_level) word[bda_pkg::KEY_UP]    = 1'b0;
		if (jy < cfg.lower_press_level)   word[bda_pkg::KEY_DOWN]  = 1'b1;
		if (jy > cfg.lower_release_level) word[bda_pkg::KEY_DOWN]  = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			for (int i = 0; i < bda_pkg::BUTTONS; i++) begin
				integ_q[i] <= '0;
			end
		end else if (en) begin
			held_q <= word;
			for (int i = 0; i < bda_pkg::BUTTONS; i++) begin
				integ_q[i] <= integ_d[i];
			end
		end
	end

	// An integrator only reaches its bounds through the paths that set or clear the key
	for (genvar g = 0; g < bda_pkg::BUTTONS; g++) begin : g_chk
		a_full_is_held: assert property (@(posedge clk) disable iff (!arst_n)
			(integ_q[g] == bda_pkg::INTEG_W'(bda_pkg::INTEG_MAX)) |-> held_q[g])
			else $error("integrator full but key not held");
		a_empty_is_free: assert property (@(posedge clk) disable iff (!arst_n)
			(integ_q[g] == '0) |-> !held_q[g])
			else $error("integrator empty but key held");
	end

endmodule

### sv/bda_repeat.sv
module bda_repeat (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  bda_pkg::cfg_t                     cfg,
	input  logic [bda_pkg::ALL_KEYS-1:0]      held_old,
	input  logic [bda_pkg::ALL_KEYS-1:0]      held_new,
	output logic [bda_pkg::ALL_KEYS-1:0]      presses
);

	logic [bda_pkg::COUNT_W-1:0] count_q [bda_pkg::ALL_KEYS];
	logic [bda_pkg::COUNT_W-1:0] count_d [bda_pkg::ALL_KEYS];
	logic [bda_pkg::REPEAT_W-1:0] period;
	logic [bda_pkg::COUNT_W:0]    top;
	logic [bda_pkg::COUNT_W:0]    delay_x;

	assign period  = (cfg.repeat_period == '0) ? bda_pkg::REPEAT_W'(1) : cfg.repeat_period;
	assign delay_x = (bda_pkg::COUNT_W+1)'(cfg.repeat_delay);
	assign top     = delay_x + (bda_pkg::COUNT_W+1)'(period);

	always_comb begin
		logic [bda_pkg::COUNT_W:0] c;
		c       = '0;
		presses = ~held_old & held_new;
		for (int i = 0; i < bda_pkg::ALL_KEYS; i++) begin
			c = (bda_pkg::COUNT_W+1)'(count_q[i]) + (bda_pkg::COUNT_W+1)'(1);
			if (c >= top) c = delay_x;
			if (held_new[i]) begin
				if (c == delay_x) presses[i] = 1'b1;
				count_d[i] = c[bda_pkg::COUNT_W-1:0];
			end else begin
				count_d[i] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bda_pkg::ALL_KEYS; i++) begin
				count_q[i] <= '0;
			end
		end else if (en) begin
			for (int i = 0; i < bda_pkg::ALL_KEYS; i++) begin
				count_q[i] <= count_d[i];
			end
		end
	end

	// A released key keeps its hold counter at zero
	for (genvar g = 0; g < bda_pkg::ALL_KEYS; g++) begin : g_chk
		a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
			!held_old[g] |-> (count_q[g] == '0))
			else $error("hold counter running on a released key");
	end

endmodule

### sv/button_debounce_autorepeat_unit.sv
// Results pass through an input register and a result register.
// Throughput: one scan tick per cycle; input stays ready while the result
// register is empty or being taken, so stalls on the output back up the input.
// Reset (arst_n low, asynchronous): integrators, held keys, hold counters and
// valid flags clear; configuration registers return to their default values.
module button_debounce_autorepeat_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// raw_buttons[4:0], joy_x[16:5], joy_y[28:17], zero fill above
	input  logic [bda_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// held[8:0], presses[17:9], zero fill above
	output logic [bda_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bda_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [bda_pkg::CFG_DATA_W-1:0]    cfg_data
);

	bda_pkg::cfg_t cfg;

	logic                          valid_s1;
	logic [bda_pkg::BUTTONS-1:0]   raw_s1;
	logic [bda_pkg::LEVEL_W-1:0]   jx_s1;
	logic [bda_pkg::LEVEL_W-1:0]   jy_s1;
	logic                          valid_s2;
	logic [bda_pkg::ALL_KEYS-1:0]  held_s2;
	logic [bda_pkg::ALL_KEYS-1:0]  presses_s2;

	logic                          out_free;
	logic                          advance;
	logic [bda_pkg::ALL_KEYS-1:0]  held_old;
	logic [bda_pkg::ALL_KEYS-1:0]  held_new;
	logic [bda_pkg::ALL_KEYS-1:0]  presses;

	assign out_free      = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	bda_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			raw_s1 <= s_axis_tdata[bda_pkg::BUTTONS-1:0];
			jx_s1  <= s_axis_tdata[bda_pkg::BUTTONS +: bda_pkg::LEVEL_W];
			jy_s1  <= s_axis_tdata[bda_pkg::BUTTONS + bda_pkg::LEVEL_W +: bda_pkg::LEVEL_W];
		end
	end

	bda_debounce u_debounce (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.cfg      (cfg),
		.raw      (raw_s1),
		.jx       (jx_s1),
		.jy       (jy_s1),
		.held_old (held_old),
		.held_new (held_new)
	);

	bda_repeat u_repeat (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.cfg      (cfg),
		.held_old (held_old),
		.held_new (held_new),
		.presses  (presses)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			held_s2    <= held_new;
			presses_s2 <= presses;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {(bda_pkg::OUT_TDATA_W - bda_pkg::OUT_FIELDS_W)'(0),
	                        presses_s2, held_s2};

	// A press is only ever reported for a key that is held in the same result
	a_press_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((presses_s2 & ~held_s2) == '0))
		else $error("press reported on a key that is not held");

	// With the result register empty the input side must be open
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_axis_tready)
		else $error("input stalled with an empty result register");

endmodule

### tb/sv/tb_button_debounce_autorepeat_unit.sv
module tb_button_debounce_autorepeat_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import bda_pkg::*;

	localparam int LONG_HOLD   = 120;
	localparam int QUIET_LIMIT = 1000;
	localparam int BTN_SEL_W   = $clog2(BUTTONS);

	typedef logic [7:0][CFG_DATA_W-1:0] reg_set_t;

	typedef struct packed {
		bit [ALL_KEYS-1:0] presses;
		bit [ALL_KEYS-1:0] held;
	} key_word_t;

	class key_scoreboard;
		bit [STEP_W-1:0]   step_up, step_down;
		bit [LEVEL_W-1:0]  up_press, up_release, lo_press, lo_release;
		bit [REPEAT_W-1:0] rep_delay, rep_period;
		int unsigned       integ [BUTTONS];
		bit [ALL_KEYS-1:0] held_keys;
		bit [COUNT_W-1:0]  hold_cnt [ALL_KEYS];
		key_word_t         pending_words [$];
		int                errors;

		function new();
			step_up    = 1;
			step_down  = 1;
			up_press   = 3000;
			up_release = 2800;
			lo_press   = 1000;
			lo_release = 1200;
			rep_delay  = 30;
			rep_period = 3;
			held_keys  = '0;
			errors     = 0;
			foreach (integ[i]) integ[i] = 0;
			foreach (hold_cnt[i]) hold_cnt[i] = '0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_STEP_UP:       step_up    = val[STEP_W-1:0];
				CFG_STEP_DOWN:     step_down  = val[STEP_W-1:0];
				CFG_UPPER_PRESS:   up_press   = val[LEVEL_W-1:0];
				CFG_UPPER_RELEASE: up_release = val[LEVEL_W-1:0];
				CFG_LOWER_PRESS:   lo_press   = val[LEVEL_W-1:0];
				CFG_LOWER_RELEASE: lo_release = val[LEVEL_W-1:0];
				CFG_REPEAT_DELAY:  rep_delay  = val[REPEAT_W-1:0];
				CFG_REPEAT_PERIOD: rep_period = val[REPEAT_W-1:0];
				default: ;
			endcase
		endfunction

		// release test is applied after press test, so release wins on overlap
		function bit [ALL_KEYS-1:0] axis_keys(bit [ALL_KEYS-1:0] w, bit [LEVEL_W-1:0] s,
				int hi, int lo);
			if (s > up_press) w[hi] = 1'b1;
			if (s < up_release) w[hi] = 1'b0;
			if (s < lo_press) w[lo] = 1'b1;
			if (s > lo_release) w[lo] = 1'b0;
			return w;
		endfunction

		function void note_tick(bit [BUTTONS-1:0] raw, bit [LEVEL_W-1:0] jx,
				bit [LEVEL_W-1:0] jy);
			bit [ALL_KEYS-1:0] prev_keys, keys, fresh;
			int unsigned acc, cnt, period, top;
			key_word_t w;
			prev_keys = held_keys;
			keys = held_keys;
			period = (rep_period == 0) ? 1 : rep_period;
			top = rep_delay + period;
			for (int i = 0; i < BUTTONS; i++) begin
				acc = integ[i];
				if (raw[i]) begin
					acc += step_up;
					if (acc >= INTEG_MAX) begin
						acc = INTEG_MAX;
						keys[i] = 1'b1;
					end
				end else if (acc <= step_down) begin
					acc = 0;
					keys[i] = 1'b0;
				end else begin
					acc -= step_down;
				end
				integ[i] = acc;
			end
			keys = axis_keys(keys, jx, KEY_RIGHT, KEY_LEFT);
			keys = axis_keys(keys, jy, KEY_UP, KEY_DOWN);
			fresh = ~prev_keys & keys;
			for (int i = 0; i < ALL_KEYS; i++) begin
				if (keys[i]) begin
					cnt = hold_cnt[i] + 1;
					if (cnt >= top) cnt = rep_delay;
					if (cnt == rep_delay) fresh[i] = 1'b1;
					hold_cnt[i] = cnt[COUNT_W-1:0];
				end else begin
					hold_cnt[i] = '0;
				end
			end
			held_keys = keys;
			w.held = keys;
			w.presses = fresh;
			pending_words.push_back(w);
		endfunction

		function void check_result(logic [ALL_KEYS-1:0] got_held,
				logic [ALL_KEYS-1:0] got_presses);
			key_word_t w;
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected result held=%h presses=%h", $time,
					got_held, got_presses);
				errors++;
				return;
			end
			w = pending_words.pop_front();
			if (got_held !== w.held) begin
				$display("%0t: held mismatch, expected %h, actual %h", $time, w.held, got_held);
				errors++;
			end
			if (got_presses !== w.presses) begin
				$display("%0t: presses mismatch, expected %h, actual %h", $time,
					w.presses, got_presses);
				errors++;
			end
		endfunction

		function int pending();
			return pending_words.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	key_scoreboard sb;
	bit send_gaps = 1'b1;
	bit recv_gaps = 1'b1;
	bit hold_req = 1'b0;
	int quiet_cycles = 0;

	// running stimulus state: debounced-looking button levels and joystick runs
	bit [BUTTONS-1:0] btn_level = '0;
	bit [LEVEL_W-1:0] joy_x_val = 2048, joy_y_val = 2048;
	int x_run = 0, y_run = 0;

	button_debounce_autorepeat_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid === 1'b1 && m_axis_tready)
				sb.check_result(m_axis_tdata[ALL_KEYS-1:0],
					m_axis_tdata[2*ALL_KEYS-1:ALL_KEYS]);
			if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
					(m_axis_tvalid === 1'b1 && m_axis_tready) ||
					(cfg_valid && cfg_ready === 1'b1))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// result sink: random stalls, plus one long hold-off on request
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				stall = LONG_HOLD;
				hold_req = 1'b0;
			end else begin
				stall = recv_gaps ? $urandom_range(0, 11) : 0;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (m_axis_tvalid !== 1'b1);
		end
	end

	task automatic send_tick(input bit [BUTTONS-1:0] raw, input bit [LEVEL_W-1:0] jx,
			input bit [LEVEL_W-1:0] jy);
		int gap;
		gap = send_gaps ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_TDATA_W'({jy, jx, raw});
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		sb.note_tick(raw, jx, jy);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic reg_set_t make_settings(int su, int sd, int up, int ur, int lp,
			int lr, int dl, int pd);
		reg_set_t v;
		v[CFG_STEP_UP]       = CFG_DATA_W'(su);
		v[CFG_STEP_DOWN]     = CFG_DATA_W'(sd);
		v[CFG_UPPER_PRESS]   = CFG_DATA_W'(up);
		v[CFG_UPPER_RELEASE] = CFG_DATA_W'(ur);
		v[CFG_LOWER_PRESS]   = CFG_DATA_W'(lp);
		v[CFG_LOWER_RELEASE] = CFG_DATA_W'(lr);
		v[CFG_REPEAT_DELAY]  = CFG_DATA_W'(dl);
		v[CFG_REPEAT_PERIOD] = CFG_DATA_W'(pd);
		return v;
	endfunction

	// writes all eight registers back to back with valid held high
	task automatic apply_settings(input reg_set_t vals);
		cfg_reg_t r;
		drain();
		r = r.first();
		do begin
			cfg_valid <= 1'b1;
			cfg_index <= r;
			cfg_data <= vals[r];
			do @(posedge clk); while (cfg_ready !== 1'b1);
			sb.set_reg(r, vals[r]);
			r = r.next();
		end while (r != r.first());
		cfg_valid <= 1'b0;
	endtask

	// half the samples land at or near the hysteresis levels so keys flip and stay put
	function automatic bit [LEVEL_W-1:0] pick_axis();
		int base;
		int v;
		case ($urandom_range(0, 5))
			0: return LEVEL_W'($urandom_range(0, 4095));
			1: return '0;
			2: return '1;
			default: begin
				case ($urandom_range(0, 3))
					0: base = sb.up_press;
					1: base = sb.up_release;
					2: base = sb.lo_press;
					default: base = sb.lo_release;
				endcase
				v = base + $urandom_range(0, 6) - 3;
				if (v < 0) v = 0;
				if (v > 4095) v = 4095;
				return LEVEL_W'(v);
			end
		endcase
	endfunction

	task automatic run_ticks(input int count);
		bit [BUTTONS-1:0] raw;
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0) begin
				send_gaps = ($urandom_range(0, 3) != 0);
				recv_gaps = ($urandom_range(0, 3) != 0);
			end
			if (x_run == 0) begin
				joy_x_val = pick_axis();
				x_run = $urandom_range(1, 40);
			end
			if (y_run == 0) begin
				joy_y_val = pick_axis();
				y_run = $urandom_range(1, 40);
			end
			x_run--;
			y_run--;
			if ($urandom_range(0, 15) == 0)
				btn_level[BTN_SEL_W'($urandom_range(0, BUTTONS - 1))] ^= 1'b1;
			raw = btn_level;
			// contact bounce on one bit, and now and then pure noise
			if ($urandom_range(0, 9) == 0)
				raw[BTN_SEL_W'($urandom_range(0, BUTTONS - 1))] ^= 1'b1;
			if ($urandom_range(0, 19) == 0)
				raw = BUTTONS'($urandom);
			send_tick(raw, joy_x_val, joy_y_val);
		end
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: thresholds and their exact edges on both axes
		send_tick(5'h00, 12'd0, 12'd0);
		send_tick(5'h1f, 12'd4095, 12'd4095);
		send_tick(5'h1f, 12'd3000, 12'd3000);
		send_tick(5'h1f, 12'd2800, 12'd2800);
		send_tick(5'h1f, 12'd2799, 12'd2799);
		send_tick(5'h1f, 12'd3001, 12'd3001);
		send_tick(5'h00, 12'd2048, 12'd2048);
		send_tick(5'h00, 12'd1000, 12'd1000);
		send_tick(5'h00, 12'd999, 12'd999);
		send_tick(5'h00, 12'd1200, 12'd1200);
		send_tick(5'h00, 12'd1201, 12'd1201);
		send_tick(5'h15, 12'd999, 12'd3001);
		send_tick(5'h0a, 12'd3001, 12'd999);
		send_tick(5'h1f, 12'd0, 12'd4095);
		send_tick(5'h00, 12'd4095, 12'd0);
		send_tick(5'h1f, 12'hAAA, 12'h555);
		send_tick(5'h1f, 12'h555, 12'hAAA);
		send_tick(5'h00, 12'd2048, 12'd2048);

		apply_settings(make_settings(64, 64, 3000, 2800, 1000, 1200, 4, 2));
		run_ticks(150);
		hold_req = 1'b1;
		run_ticks(120);
		drain();
		run_ticks(80);

		// largest steps, widest hysteresis, shortest nonzero repeat
		apply_settings(make_settings(255, 255, 0, 4095, 4095, 0, 1, 1));
		run_ticks(150);

		// zero steps and zero repeat timing via masked data; overlapping levels
		apply_settings(make_settings('hF00, 'h100, 100, 200, 300, 250, 'hC00, 0));
		run_ticks(150);

		// longest repeat timing, shrinking any count left over from before
		apply_settings(make_settings(1, 255, 4095, 4095, 0, 0, 1023, 1023));
		run_ticks(100);

		apply_settings(make_settings(37, 19, 3000, 2800, 1000, 1200, 7, 5));
		run_ticks(300);

		repeat (3) begin
			apply_settings(make_settings($urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095)));
			run_ticks(100);
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
